// ----- hw/rtl/lexical_token_scanner_macros.svh -----
// Assertion macros shared by the front-end and queue RTL files.
`ifndef LEXICAL_TOKEN_SCANNER_MACROS_SVH
`define LEXICAL_TOKEN_SCANNER_MACROS_SVH

`ifndef SYNTHESIS
`define LTS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("scanner assertion failed");
`define LTS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("scanner assertion failed");
`else
`define LTS_ASSERT(label, clk, rst, prop)
`define LTS_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- hw/rtl/lts_pkg.sv -----
// Shared types and constants for the lexical token scanner.
`default_nettype none
package lts_pkg;

   localparam int LINE_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH       = 4;
   localparam int QPTR_BITS         = $clog2(QUEUE_DEPTH);
   localparam int LINE_OUT_BITS     = 16;
   localparam int MAX_RESULTS       = 3;

   localparam logic [1:0] KIND_CHAR  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_EOF   = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic [1:0] CLASS_IDENT   = 2'd0;
   localparam logic [1:0] CLASS_INT     = 2'd1;
   localparam logic [1:0] CLASS_SPECIAL = 2'd2;

   localparam logic [1:0] ERR_EOF     = 2'd0;
   localparam logic [1:0] ERR_RBRACE  = 2'd1;
   localparam logic [1:0] ERR_ILLEGAL = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] token_class;
      logic [7:0] token_char;
      logic       name_ok;
      logic [1:0] error_code;
   } result_type;

   typedef struct packed {
      logic [1:0]                     count;
      result_type [MAX_RESULTS-1:0]   slot;
      logic [LINE_OUT_BITS-1:0]       line_number;
   } bundle_type;

   typedef struct packed {
      logic       push;
      bundle_type bundle;
   } push_type;

endpackage
`default_nettype wire

// ----- hw/rtl/lts_req_if.sv -----
// Input channel carrying one source character per transaction.
`default_nettype none
interface lts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       end_of_input;

   modport source (output valid, output character, output end_of_input, input ready);
   modport sink (input valid, input character, input end_of_input, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/lts_rsp_if.sv -----
// Result channel carrying one scanner result per transaction.
`default_nettype none
interface lts_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [1:0]  token_class;
   logic [7:0]  token_char;
   logic        name_ok;
   logic [1:0]  error_code;
   logic [15:0] line_number;
   logic        last_of_run;

   modport source (output valid, output kind, output token_class, output token_char,
                   output name_ok, output error_code, output line_number,
                   output last_of_run, input ready);
   modport sink (input valid, input kind, input token_class, input token_char,
                 input name_ok, input error_code, input line_number,
                 input last_of_run, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/lts_front.sv -----
// Front end: accepts characters, tracks scan state and builds result bundles.
`default_nettype none
`include "lexical_token_scanner_macros.svh"
module lts_front #(
   parameter int LINE_BITS = lts_pkg::LINE_BITS_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   lts_req_if.sink            req,
   input  wire logic          queue_full,
   output lts_pkg::push_type  push_out
);
   import lts_pkg::*;

   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_COMMENT = 3'd1;
   localparam logic [2:0] MODE_IDENT   = 3'd2;
   localparam logic [2:0] MODE_INT     = 3'd3;
   localparam logic [2:0] MODE_HALT    = 3'd4;

   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LF     = 8'h0A;

   function automatic logic is_lower(input logic [7:0] c);
      return c inside {[8'h61:8'h7A]};
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
   endfunction

   function automatic logic is_special(input logic [7:0] c);
      return c inside {8'h3D, 8'h3A, 8'h2C, 8'h3B, 8'h2E, 8'h2B, 8'h2D};
   endfunction

   logic [2:0]           mode_ff, mode_in;
   logic                 after_newline_ff, after_newline_in;
   logic [LINE_BITS-1:0] line_count_ff, line_count_in;
   logic                 last_us_ff, last_us_in;
   logic                 double_us_ff, double_us_in;
   logic                 accept;
   logic [1:0]           n;
   logic                 rescan;
   logic [31:0]          line_wide;
   logic [7:0]           c;
   bundle_type           bundle;

   assign req.ready = !queue_full;
   assign accept    = req.valid && !queue_full;
   assign c         = req.character;

   always_comb begin
      mode_in          = mode_ff;
      after_newline_in = after_newline_ff;
      line_count_in    = line_count_ff;
      last_us_in       = last_us_ff;
      double_us_in     = double_us_ff;
      bundle           = '0;
      n                = 2'd0;
      rescan           = 1'b0;
      line_wide        = 32'd0;
      if (mode_ff == MODE_HALT) begin
         rescan = 1'b0;
      end else if (req.end_of_input) begin
         if (mode_ff == MODE_IDLE) begin
            bundle.slot[n] = '{KIND_EOF, CLASS_IDENT, 8'd0, 1'b0, ERR_EOF};
         end else begin
            bundle.slot[n] = '{KIND_ERROR, CLASS_IDENT, 8'd0, 1'b0, ERR_EOF};
            mode_in = MODE_HALT;
         end
         n = n + 2'd1;
      end else begin
         if (after_newline_ff && (line_count_ff != '1)) begin
            line_count_in = line_count_ff + LINE_BITS'(1);
         end
         after_newline_in = (c == CH_LF);
         rescan = 1'b1;
         case (mode_ff)
            MODE_COMMENT: begin
               rescan = 1'b0;
               if (c == CH_RBRACE) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_IDENT: begin
               if (is_lower(c) || is_digit(c) || (c == CH_UNDER)) begin
                  rescan = 1'b0;
                  if (c == CH_UNDER) begin
                     if (last_us_ff) begin
                        double_us_in = 1'b1;
                     end
                     last_us_in = 1'b1;
                  end else begin
                     last_us_in = 1'b0;
                  end
                  bundle.slot[n] = '{KIND_CHAR, CLASS_IDENT, c, 1'b0, ERR_EOF};
                  n = n + 2'd1;
               end else begin
                  bundle.slot[n] = '{KIND_END, CLASS_IDENT, 8'd0,
                                     !last_us_ff && !double_us_ff, ERR_EOF};
                  n = n + 2'd1;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_INT: begin
               if (is_digit(c)) begin
                  rescan = 1'b0;
                  bundle.slot[n] = '{KIND_CHAR, CLASS_INT, c, 1'b0, ERR_EOF};
                  n = n + 2'd1;
               end else begin
                  bundle.slot[n] = '{KIND_END, CLASS_INT, 8'd0, 1'b0, ERR_EOF};
                  n = n + 2'd1;
                  mode_in = MODE_IDLE;
               end
            end
            default: begin
               rescan = 1'b1;
            end
         endcase
         if (rescan) begin
            if (c == CH_LBRACE) begin
               mode_in = MODE_COMMENT;
            end else if (c == CH_RBRACE) begin
               bundle.slot[n] = '{KIND_ERROR, CLASS_IDENT, 8'd0, 1'b0, ERR_RBRACE};
               n = n + 2'd1;
               mode_in = MODE_HALT;
            end else if (is_space(c)) begin
               mode_in = mode_in;
            end else if (is_special(c)) begin
               bundle.slot[n] = '{KIND_CHAR, CLASS_SPECIAL, c, 1'b0, ERR_EOF};
               n = n + 2'd1;
               bundle.slot[n] = '{KIND_END, CLASS_SPECIAL, 8'd0, 1'b0, ERR_EOF};
               n = n + 2'd1;
            end else if (is_lower(c)) begin
               last_us_in   = 1'b0;
               double_us_in = 1'b0;
               bundle.slot[n] = '{KIND_CHAR, CLASS_IDENT, c, 1'b0, ERR_EOF};
               n = n + 2'd1;
               mode_in = MODE_IDENT;
            end else if (is_digit(c)) begin
               bundle.slot[n] = '{KIND_CHAR, CLASS_INT, c, 1'b0, ERR_EOF};
               n = n + 2'd1;
               mode_in = MODE_INT;
            end else begin
               bundle.slot[n] = '{KIND_ERROR, CLASS_IDENT, 8'd0, 1'b0, ERR_ILLEGAL};
               n = n + 2'd1;
               mode_in = MODE_HALT;
            end
         end
      end
      line_wide          = 32'(line_count_in);
      bundle.line_number = (line_wide > 32'h0000FFFF) ? 16'hFFFF : line_wide[15:0];
      bundle.count       = n;
   end

   assign push_out.push   = accept && (n != 2'd0);
   assign push_out.bundle = bundle;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_IDLE;
         after_newline_ff <= 1'b1;
         line_count_ff    <= '0;
         last_us_ff       <= 1'b0;
         double_us_ff     <= 1'b0;
      end else if (accept) begin
         mode_ff          <= mode_in;
         after_newline_ff <= after_newline_in;
         line_count_ff    <= line_count_in;
         last_us_ff       <= last_us_in;
         double_us_ff     <= double_us_in;
      end
   end

   `LTS_ASSERT(a_halt_silent, clock, reset, (mode_ff == MODE_HALT) |-> !push_out.push)
   `LTS_ASSERT(a_halt_sticks, clock, reset, (mode_ff == MODE_HALT) |=> (mode_ff == MODE_HALT))

endmodule
`default_nettype wire

// ----- hw/rtl/lts_queue.sv -----
// Short queue of result bundles between the front and back ends.
`default_nettype none
`include "lexical_token_scanner_macros.svh"
module lts_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lts_pkg::push_type push_in,
   input  wire logic             pop,
   output lts_pkg::bundle_type   head,
   output logic                  empty,
   output logic                  full
);
   import lts_pkg::*;

   bundle_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]        count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_in.push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_BITS+1)'(push_in.push) - (QPTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_in.push) begin
         entry_ff[wr_ptr_ff] <= push_in.bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `LTS_ASSERT(a_no_push_full, clock, reset, push_in.push |-> !full)
   `LTS_ASSERT(a_no_pop_empty, clock, reset, pop |-> !empty)
   `LTS_ASSERT(a_ptr_gap, clock, reset,
      (QPTR_BITS'(wr_ptr_ff - rd_ptr_ff) == count_ff[QPTR_BITS-1:0]))

endmodule
`default_nettype wire

// ----- hw/rtl/lts_back.sv -----
// Back end: unpacks bundles into single results held in an output register.
`default_nettype none
module lts_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lts_pkg::bundle_type head,
   input  wire logic                empty,
   output logic                     pop,
   lts_rsp_if.source                rsp
);
   import lts_pkg::*;

   logic [1:0]               idx_ff, idx_in;
   logic                     valid_ff, valid_in;
   result_type               res_ff;
   logic [LINE_OUT_BITS-1:0] line_ff;
   logic                     last_ff;
   logic                     load;
   logic                     last;

   assign load = !empty && (!valid_ff || rsp.ready);
   assign last = (idx_ff == (head.count - 2'd1));
   assign pop  = load && last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = last ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff  <= head.slot[idx_ff];
         line_ff <= head.line_number;
         last_ff <= last;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.kind        = res_ff.kind;
   assign rsp.token_class = res_ff.token_class;
   assign rsp.token_char  = res_ff.token_char;
   assign rsp.name_ok     = res_ff.name_ok;
   assign rsp.error_code  = res_ff.error_code;
   assign rsp.line_number = line_ff;
   assign rsp.last_of_run = last_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/lexical_token_scanner.sv -----
// Top level of the lexical token scanner.
//
//   channel   | direction | contents
//   req_chan  | in        | character, end_of_input
//   rsp_chan  | out       | kind, token_class, token_char, name_ok, error_code,
//             |           | line_number, last_of_run
//
// Each character yields zero to three results; they leave one per cycle while
// rsp_chan is ready. The front end classifies each character combinationally
// and writes a bundle into a four-entry queue, so input stalls only when that
// queue is full. Each result passes through a queue entry and the output register.
// Reset is synchronous and clears the scan state, the queue and the output valid flag.
// After an error the scanner keeps taking transactions but gives no results until reset.
`default_nettype none
module lexical_token_scanner #(
   parameter int LINE_BITS = lts_pkg::LINE_BITS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lts_req_if.sink    req_chan,
   lts_rsp_if.source  rsp_chan
);
   import lts_pkg::*;

   push_type   push;
   bundle_type head;
   logic       empty;
   logic       full;
   logic       pop;

   lts_front #(
      .LINE_BITS (LINE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .queue_full (full),
      .push_out   (push)
   );

   lts_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .pop     (pop),
      .head    (head),
      .empty   (empty),
      .full    (full)
   );

   lts_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .empty (empty),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule
`default_nettype wire

// ----- dv/lts_scoreboard.sv -----
// Scoreboard that predicts the scanner's results from accepted characters and checks them.
module lts_scoreboard #(
   parameter int LINE_BITS = lts_pkg::LINE_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   lts_req_if   req_chan,
   lts_rsp_if   rsp_chan,
   output int   fail_count,
   output int   pending_count,
   output int   result_count
);
   import lts_pkg::*;

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_COMMENT,
      SCAN_IDENT,
      SCAN_INT,
      SCAN_HALT
   } scan_mode_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  token_class;
      logic [7:0]  token_char;
      logic        name_ok;
      logic [1:0]  error_code;
      logic [15:0] line_number;
      logic        last_of_run;
   } scan_result_type;

   localparam logic [1:0] CLASS_NONE    = 2'd0;
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [7:0] CH_LBRACE     = "{";
   localparam logic [7:0] CH_RBRACE     = "}";
   localparam logic [7:0] CH_UNDERSCORE = "_";
   localparam logic [7:0] CH_NEWLINE    = 8'd10;

   scan_mode_type        mode;
   logic                 after_newline;
   logic [LINE_BITS-1:0] line_count;
   logic                 trailing_underscore;
   logic                 double_underscore;
   scan_result_type      expected_results [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      result_count  = 0;
   end

   function automatic logic is_lower(input logic [7:0] c);
      return c >= "a" && c <= "z";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_special(input logic [7:0] c);
      return c == "=" || c == ":" || c == "," || c == ";" || c == "." ||
             c == "+" || c == "-";
   endfunction

   function automatic scan_result_type make_result(input logic [1:0] kind,
                                                   input logic [1:0] token_class,
                                                   input logic [7:0] token_char,
                                                   input logic       name_ok,
                                                   input logic [1:0] error_code);
      scan_result_type r;
      r.kind        = kind;
      r.token_class = token_class;
      r.token_char  = token_char;
      r.name_ok     = name_ok;
      r.error_code  = error_code;
      r.line_number = (line_count > 65535) ? 16'hFFFF : 16'(line_count);
      r.last_of_run = 1'b0;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      if (fail_count < 100) begin
         $display("%0t: scanner result %0d: %s", $time, result_count, what);
      end
      fail_count++;
   endtask

   task automatic scan_character(input logic [7:0] c, input logic eoi);
      scan_result_type run [$];
      logic            rescan;
      rescan = 1'b0;
      if (mode == SCAN_HALT) begin
         return;
      end
      if (eoi) begin
         if (mode == SCAN_IDLE) begin
            run.push_back(make_result(KIND_EOF, CLASS_NONE, 8'd0, 1'b0, ERR_NONE));
         end else begin
            run.push_back(make_result(KIND_ERROR, CLASS_NONE, 8'd0, 1'b0, ERR_EOF));
            mode = SCAN_HALT;
         end
      end else begin
         if (after_newline && line_count != {LINE_BITS{1'b1}}) begin
            line_count = line_count + 1'b1;
         end
         after_newline = (c == CH_NEWLINE);
         case (mode)
            SCAN_COMMENT: begin
               if (c == CH_RBRACE) begin
                  mode = SCAN_IDLE;
               end
            end
            SCAN_IDENT: begin
               if (is_lower(c) || is_digit(c) || c == CH_UNDERSCORE) begin
                  if (c == CH_UNDERSCORE) begin
                     if (trailing_underscore) begin
                        double_underscore = 1'b1;
                     end
                     trailing_underscore = 1'b1;
                  end else begin
                     trailing_underscore = 1'b0;
                  end
                  run.push_back(make_result(KIND_CHAR, CLASS_IDENT, c, 1'b0, ERR_NONE));
               end else begin
                  run.push_back(make_result(KIND_END, CLASS_IDENT, 8'd0,
                                            !trailing_underscore && !double_underscore,
                                            ERR_NONE));
                  mode   = SCAN_IDLE;
                  rescan = 1'b1;
               end
            end
            SCAN_INT: begin
               if (is_digit(c)) begin
                  run.push_back(make_result(KIND_CHAR, CLASS_INT, c, 1'b0, ERR_NONE));
               end else begin
                  run.push_back(make_result(KIND_END, CLASS_INT, 8'd0, 1'b0, ERR_NONE));
                  mode   = SCAN_IDLE;
                  rescan = 1'b1;
               end
            end
            default: begin
               rescan = 1'b1;
            end
         endcase
         if (rescan) begin
            if (c == CH_LBRACE) begin
               mode = SCAN_COMMENT;
            end else if (c == CH_RBRACE) begin
               run.push_back(make_result(KIND_ERROR, CLASS_NONE, 8'd0, 1'b0, ERR_RBRACE));
               mode = SCAN_HALT;
            end else if (is_space(c)) begin
            end else if (is_special(c)) begin
               run.push_back(make_result(KIND_CHAR, CLASS_SPECIAL, c, 1'b0, ERR_NONE));
               run.push_back(make_result(KIND_END, CLASS_SPECIAL, 8'd0, 1'b0, ERR_NONE));
            end else if (is_lower(c)) begin
               trailing_underscore = 1'b0;
               double_underscore   = 1'b0;
               run.push_back(make_result(KIND_CHAR, CLASS_IDENT, c, 1'b0, ERR_NONE));
               mode = SCAN_IDENT;
            end else if (is_digit(c)) begin
               run.push_back(make_result(KIND_CHAR, CLASS_INT, c, 1'b0, ERR_NONE));
               mode = SCAN_INT;
            end else begin
               run.push_back(make_result(KIND_ERROR, CLASS_NONE, 8'd0, 1'b0, ERR_ILLEGAL));
               mode = SCAN_HALT;
            end
         end
      end
      if (run.size() != 0) begin
         run[run.size()-1].last_of_run = 1'b1;
      end
      foreach (run[i]) begin
         expected_results.push_back(run[i]);
      end
   endtask

   always @(posedge clock) begin : monitor
      scan_result_type got;
      scan_result_type want;
      if (reset) begin
         mode                = SCAN_IDLE;
         after_newline       = 1'b1;
         line_count          = '0;
         trailing_underscore = 1'b0;
         double_underscore   = 1'b0;
         expected_results.delete();
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            scan_character(req_chan.character, req_chan.end_of_input);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.kind        = rsp_chan.kind;
            got.token_class = rsp_chan.token_class;
            got.token_char  = rsp_chan.token_char;
            got.name_ok     = rsp_chan.name_ok;
            got.error_code  = rsp_chan.error_code;
            got.line_number = rsp_chan.line_number;
            got.last_of_run = rsp_chan.last_of_run;
            result_count++;
            if (expected_results.size() == 0) begin
               report_mismatch("transaction arrived with no result expected");
            end else begin
               want = expected_results.pop_front();
               if (got.kind !== want.kind) begin
                  report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
               end
               if (got.token_class !== want.token_class) begin
                  report_mismatch($sformatf("token_class %0d, expected %0d",
                                            got.token_class, want.token_class));
               end
               if (got.token_char !== want.token_char) begin
                  report_mismatch($sformatf("token_char 0x%02h, expected 0x%02h",
                                            got.token_char, want.token_char));
               end
               if (got.name_ok !== want.name_ok) begin
                  report_mismatch($sformatf("name_ok %0d, expected %0d",
                                            got.name_ok, want.name_ok));
               end
               if (got.error_code !== want.error_code) begin
                  report_mismatch($sformatf("error_code %0d, expected %0d",
                                            got.error_code, want.error_code));
               end
               if (got.line_number !== want.line_number) begin
                  report_mismatch($sformatf("line_number %0d, expected %0d",
                                            got.line_number, want.line_number));
               end
               if (got.last_of_run !== want.last_of_run) begin
                  report_mismatch($sformatf("last_of_run %0d, expected %0d",
                                            got.last_of_run, want.last_of_run));
               end
            end
         end
      end
      pending_count = expected_results.size();
   end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top that drives source text into the scanner and gives the verdict.
module tb_top;

   logic  clock;
   logic  reset;
   int    send_idle_pct;
   int    recv_idle_pct;
   int    chars_sent;
   int    fail_count;
   int    pending_count;
   int    result_count;
   string ending_name;

   lts_req_if req_chan ();
   lts_rsp_if rsp_chan ();

   lexical_token_scanner dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   lts_scoreboard scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : receiver
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_item(input logic [7:0] ch, input logic eoi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.character    <= ch;
      req_chan.end_of_input <= eoi;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) begin
         send_item(text[i], 1'b0);
      end
   endtask

   function automatic logic [7:0] pick_space();
      case ($urandom_range(0, 5))
         0:       return " ";
         1:       return 8'd9;
         2:       return 8'd10;
         3:       return 8'd11;
         4:       return 8'd12;
         default: return 8'd13;
      endcase
   endfunction

   function automatic logic [7:0] pick_illegal();
      string punct;
      punct = "!\"#$%&'()*/<>?@[\\]^`|~";
      case ($urandom_range(0, 3))
         0:       return 8'($urandom_range("A", "Z"));
         1:       return 8'($urandom_range(128, 255));
         2:       return $urandom_range(1) ? 8'($urandom_range(14, 31))
                                           : 8'($urandom_range(0, 8));
         default: return punct[$urandom_range(0, punct.len() - 1)];
      endcase
   endfunction

   task automatic send_fragment();
      int         pick;
      logic [7:0] b;
      string      specials;
      specials = "=:,;.+-";
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         send_item(8'($urandom_range("a", "z")), 1'b0);
         repeat ($urandom_range(0, 7)) begin
            case ($urandom_range(0, 3))
               0, 1:    send_item(8'($urandom_range("a", "z")), 1'b0);
               2:       send_item(8'($urandom_range("0", "9")), 1'b0);
               default: send_item("_", 1'b0);
            endcase
         end
      end else if (pick < 50) begin
         repeat ($urandom_range(1, 6)) begin
            send_item(8'($urandom_range("0", "9")), 1'b0);
         end
      end else if (pick < 65) begin
         send_item(specials[$urandom_range(0, 6)], 1'b0);
      end else if (pick < 80) begin
         repeat ($urandom_range(1, 3)) begin
            send_item(pick_space(), 1'b0);
         end
      end else if (pick < 92) begin
         send_item("{", 1'b0);
         repeat ($urandom_range(0, 6)) begin
            do begin
               b = 8'($urandom_range(0, 255));
            end while (b == "}");
            send_item(b, 1'b0);
         end
         send_item("}", 1'b0);
      end else begin
         send_item(pick_space(), 1'b0);
         send_item(8'($urandom), 1'b1);
      end
   endtask

   task automatic send_random(input int count);
      int target;
      target = chars_sent + count;
      while (chars_sent < target) begin
         send_fragment();
      end
   endtask

   // The scanner halts for good after an error, so only one error ends the run.
   task automatic send_fatal_ending();
      case ($urandom_range(0, 4))
         0: begin
            ending_name = "end of input inside a comment";
            send_text("{ab");
            send_item(8'($urandom), 1'b1);
         end
         1: begin
            ending_name = "end of input inside an identifier";
            send_text(" ab_");
            send_item(8'($urandom), 1'b1);
         end
         2: begin
            ending_name = "end of input inside an integer";
            send_text(" 42");
            send_item(8'($urandom), 1'b1);
         end
         3: begin
            ending_name = "closing brace";
            send_text(" x}");
         end
         default: begin
            ending_name = "illegal symbol";
            send_text(" 7");
            send_item(pick_illegal(), 1'b0);
         end
      endcase
      repeat (10) begin
         send_item(8'($urandom), 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin : stimulus
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.character    = 8'd0;
      req_chan.end_of_input = 1'b0;
      send_idle_pct         = 12;
      recv_idle_pct         = 84;
      chars_sent            = 0;
      ending_name           = "";
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_text("a_9z_;q__0\t09=:{");
      send_item(8'hFF, 1'b0);
      send_text("\n}my\r");
      send_item(8'h00, 1'b1);
      send_item(8'd11, 1'b0);
      send_item(8'd12, 1'b0);
      send_text(".");
      send_random(40);

      send_idle_pct = 84;
      recv_idle_pct = 12;
      send_random(40);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(40);
      send_text("k ");
      send_fatal_ending();
      req_chan.valid <= 1'b0;

      wait (pending_count == 0);
      repeat (16) @(posedge clock);
      $display("Sent %0d characters over three idling phases, ending on %s.",
               chars_sent, ending_name);
      $display("Checked %0d results against the prediction.", result_count);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
